FILE: rtl/core/servo_keyframe_interpolator_core_defines.svh
// Assertion macros for the servo keyframe interpolator core.
`ifndef SERVO_KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH
`define SERVO_KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SKI_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ski: invariant violated");
`define SKI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ski: sequence violated");
`else
`define SKI_ASSERT_ALWAYS(name, prop)
`define SKI_ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: rtl/core/ski_pkg.sv
// Types, constants and helpers shared by the servo keyframe interpolator.
package ski_pkg;

    localparam int NUM_SERVOS = 8;
    localparam int ANGLE_W    = 8;
    localparam int DUR_W      = 16;
    localparam int PROD_W     = DUR_W + ANGLE_W;
    localparam int SERVO_W    = $clog2(NUM_SERVOS);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [NUM_SERVOS-1:0][ANGLE_W-1:0] ski_pose_t;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       target_0;
        logic [7:0]       target_1;
        logic [7:0]       target_2;
        logic [7:0]       target_3;
        logic [7:0]       target_4;
        logic [7:0]       target_5;
        logic [7:0]       target_6;
        logic [7:0]       target_7;
        logic [DUR_W-1:0] duration_ms;
    } ski_cmd_t;

    typedef struct packed {
        logic [7:0] angle_0;
        logic [7:0] angle_1;
        logic [7:0] angle_2;
        logic [7:0] angle_3;
        logic [7:0] angle_4;
        logic [7:0] angle_5;
        logic [7:0] angle_6;
        logic [7:0] angle_7;
        logic [7:0] update_mask;
        logic       keyframe_done;
    } ski_res_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DUR_W-1:0]  divisor;
    } ski_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } ski_div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_DIV,
        S_LOAD_WAIT,
        S_SERVO,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH,
        S_OUT
    } ski_state_t;

    function automatic ski_pose_t ski_targets(input ski_cmd_t c);
        ski_pose_t p;
        p[0] = c.target_0;
        p[1] = c.target_1;
        p[2] = c.target_2;
        p[3] = c.target_3;
        p[4] = c.target_4;
        p[5] = c.target_5;
        p[6] = c.target_6;
        p[7] = c.target_7;
        return p;
    endfunction

    function automatic ski_res_t ski_pack_res(input ski_pose_t a, input logic [7:0] mask,
                                              input logic done);
        ski_res_t r;
        r.angle_0       = a[0];
        r.angle_1       = a[1];
        r.angle_2       = a[2];
        r.angle_3       = a[3];
        r.angle_4       = a[4];
        r.angle_5       = a[5];
        r.angle_6       = a[6];
        r.angle_7       = a[7];
        r.update_mask   = mask;
        r.keyframe_done = done;
        return r;
    endfunction

endpackage

FILE: rtl/core/servo_keyframe_interpolator_core.sv
// Load: accept, duration / TICK_MS by reciprocal multiply, commit, output.
// Tick: accept, then per servo a pass if it is at rest, or a multiply and a 24-step
// divide on the shared divider if it moves, then commit and output. Idle tick: accept,
// then output. One item at a time; the next item is taken while a result waits.
// Reset (async, active low) clears poses, duration, tick counters and the active flag.
`include "servo_keyframe_interpolator_core_defines.svh"

module servo_keyframe_interpolator_core
    import ski_pkg::*;
#(
    parameter int TICK_MS = 10
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  ski_cmd_t cmd_data,
    output logic     res_valid,
    input  logic     res_ready,
    output ski_res_t res_data
);

    localparam int LIMIT_W     = $clog2(((2 ** DUR_W) - 1) / TICK_MS + 1);
    localparam int RECIP_SH    = DUR_W + $clog2(TICK_MS);
    localparam int RECIP_W     = DUR_W + 1;
    localparam int RECIP_M     = ((2 ** RECIP_SH) + TICK_MS - 1) / TICK_MS;
    localparam int LOAD_PROD_W = DUR_W + RECIP_W;

    ski_state_t        state_reg;
    ski_state_t        state_next;

    ski_pose_t         start_pose_reg;
    ski_pose_t         goal_pose_reg;
    ski_pose_t         angle_reg;
    logic [DUR_W-1:0]  frame_duration_reg;
    logic [LIMIT_W-1:0] tick_index_reg;
    logic [LIMIT_W-1:0] tick_limit_reg;
    logic [DUR_W-1:0]  step_reg;
    logic              frame_active_reg;
    logic [SERVO_W-1:0] idx_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [7:0]        mask_reg;
    logic              done_reg;
    logic              use_start_reg;
    logic              res_valid_reg;
    ski_res_t          res_data_reg;

    ski_div_req_t      div_req;
    ski_div_rsp_t      div_rsp;

    logic              cmd_fire;
    logic              run_tick;
    logic              res_slot_free;
    logic [ANGLE_W-1:0] cur_start;
    logic [ANGLE_W-1:0] cur_goal;
    logic              falling;
    logic              pose_equal;
    logic [ANGLE_W-1:0] diff;
    logic [ANGLE_W-1:0] delta;
    logic              idx_last;
    logic [LIMIT_W:0]  tick_inc;
    logic              tick_commit;
    logic [LOAD_PROD_W-1:0] load_prod;
    logic [LIMIT_W-1:0] load_limit;

    assign cmd_fire      = cmd_valid && cmd_ready;
    assign run_tick      = frame_active_reg && (frame_duration_reg != '0);
    assign res_slot_free = !res_valid_reg || res_ready;
    assign cur_start     = start_pose_reg[idx_reg];
    assign cur_goal      = goal_pose_reg[idx_reg];
    assign falling       = cur_start > cur_goal;
    assign pose_equal    = cur_start == cur_goal;
    assign diff          = falling ? (cur_start - cur_goal) : (cur_goal - cur_start);
    assign delta         = (div_rsp.quotient > PROD_W'(diff)) ? diff
                                                              : div_rsp.quotient[ANGLE_W-1:0];
    assign idx_last      = idx_reg == SERVO_W'(NUM_SERVOS - 1);
    assign tick_inc      = {1'b0, tick_index_reg} + {{LIMIT_W{1'b0}}, 1'b1};
    assign tick_commit   = tick_inc >= {1'b0, tick_limit_reg};

    // floor(duration / TICK_MS) by reciprocal multiply, exact for all 16-bit durations
    assign load_prod     = LOAD_PROD_W'(frame_duration_reg) * LOAD_PROD_W'(RECIP_M);
    assign load_limit    = load_prod[RECIP_SH +: LIMIT_W];

    ski_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd_data.cmd == CMD_LOAD)
                        state_next = S_LOAD_DIV;
                    else if (run_tick)
                        state_next = S_SERVO;
                    else
                        state_next = S_OUT;
                end
            end
            S_LOAD_DIV:  state_next = S_LOAD_WAIT;
            S_LOAD_WAIT: state_next = S_OUT;
            S_SERVO:
            begin
                if (!pose_equal)
                    state_next = S_DIV_GO;
                else if (idx_last)
                    state_next = S_FINISH;
            end
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = idx_last ? S_FINISH : S_SERVO;
            end
            S_FINISH:    state_next = S_OUT;
            S_OUT:       if (res_slot_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready        = state_reg == S_IDLE;
        div_req.start    = state_reg == S_DIV_GO;
        div_req.dividend = prod_reg;
        div_req.divisor  = frame_duration_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            start_pose_reg     <= '0;
            goal_pose_reg      <= '0;
            frame_duration_reg <= '0;
            tick_index_reg     <= '0;
            tick_limit_reg     <= '0;
            step_reg           <= '0;
            frame_active_reg   <= 1'b0;
            idx_reg            <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && res_slot_free)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (cmd_fire && (cmd_data.cmd == CMD_LOAD))
                    begin
                        goal_pose_reg      <= ski_targets(cmd_data);
                        frame_duration_reg <= cmd_data.duration_ms;
                    end
                end
                S_LOAD_DIV:
                begin
                    tick_limit_reg   <= load_limit;
                    tick_index_reg   <= '0;
                    step_reg         <= '0;
                    frame_active_reg <= 1'b0;
                end
                S_LOAD_WAIT:
                begin
                    if (tick_limit_reg == '0)
                        start_pose_reg   <= goal_pose_reg;
                    else
                        frame_active_reg <= 1'b1;
                end
                S_SERVO:
                begin
                    if (pose_equal)
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                        idx_reg <= idx_reg + 1'b1;
                end
                S_FINISH:
                begin
                    if (tick_commit)
                    begin
                        start_pose_reg   <= goal_pose_reg;
                        frame_active_reg <= 1'b0;
                        tick_index_reg   <= '0;
                        step_reg         <= '0;
                    end
                    else
                    begin
                        tick_index_reg <= tick_inc[LIMIT_W-1:0];
                        step_reg       <= step_reg + DUR_W'(TICK_MS);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    mask_reg      <= '0;
                    done_reg      <= 1'b0;
                    use_start_reg <= !((cmd_data.cmd == CMD_TICK) && run_tick);
                end
            end
            S_LOAD_WAIT:
            begin
                if (tick_limit_reg == '0)
                    done_reg <= 1'b1;
            end
            S_SERVO:
            begin
                if (pose_equal)
                    angle_reg[idx_reg] <= cur_start;
                else
                    prod_reg <= PROD_W'(step_reg) * PROD_W'(diff);
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    angle_reg[idx_reg] <= falling ? (cur_start - delta) : (cur_start + delta);
                    mask_reg[idx_reg]  <= 1'b1;
                end
            end
            S_FINISH:
            begin
                if (tick_commit)
                    done_reg <= 1'b1;
            end
            S_OUT:
            begin
                if (res_slot_free)
                    res_data_reg <= ski_pack_res(use_start_reg ? start_pose_reg : angle_reg,
                                                 mask_reg, done_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `SKI_ASSERT_ALWAYS(a_active_index, !frame_active_reg || (tick_index_reg < tick_limit_reg))
    `SKI_ASSERT_ALWAYS(a_div_idle_start, !div_req.start || !div_rsp.busy)
    `SKI_ASSERT_NEXT(a_out_beat, (state_reg == S_OUT) && res_slot_free, res_valid && (state_reg == S_IDLE))

endmodule

FILE: rtl/core/ski_div.sv
// Restoring divider, one quotient bit per cycle.
module ski_div
    import ski_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ski_div_req_t req,
    output ski_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] dvd_reg;
    logic [DUR_W-1:0]  rem_reg;
    logic [DUR_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DUR_W:0]    rem_shift;
    logic              ge;
    logic [DUR_W:0]    rem_sub;

    assign rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge        = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DUR_W-1:0] : rem_shift[DUR_W-1:0];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule
